[hdl/itrfr_pkg.sv]
package itrfr_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd20;

  // Byte address of the timeout register
  localparam logic [APB_ADDR_W-1:0] REG_TIMEOUT_ADDR = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_byte;
    logic arm;
    logic tick;
    logic rd_issue;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic timeout_hit;
    logic rd_free;
    logic rd_last;
  } dp_status_t;

endpackage

[hdl/idle_timeout_ring_frame_receiver_core.sv]
// Idle-timeout ring frame receiver.
// Input channel (in_valid/in_ready): one transaction carries a command and a
// byte. A received byte is stored in the ring, a rising edge on the line
// clears the idle counter and arms the timeout, a tick advances the counter.
// Command code 3 is ignored.
// Output channel (out_valid/out_ready): when an armed tick brings the counter
// to timeout_ticks, every byte from the read pointer up to the write pointer
// leaves as one transaction each, in arrival order, out_msg_last on the final
// one. Equal pointers send the whole ring.
// Timing: a command that closes no message keeps in_ready high. A closing tick
// drains N bytes (1 to RING_DEPTH) at one ring read per cycle unless out_ready
// stalls, limited by the single read port of the ring memory; each byte passes
// a read and an output register, and in_ready stays low until the last read.
// A stalled out_ready holds the read pipeline and the drain pauses with it;
// no byte is lost. Reset (rst_n low, synchronous) clears pointers, counter,
// armed flag and the output stage, and loads timeout_ticks with 20. Ring
// contents are not cleared. APB register at address 0: timeout_ticks.
module idle_timeout_ring_frame_receiver_core
  import itrfr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_msg_byte,
  output logic                  out_msg_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;
  logic              timeout_we;
  logic [TICK_W-1:0] timeout_ticks;
  logic              reg_hit;

  // APB: no wait states; the timeout register is the only one decoded
  assign pready     = 1'b1;
  assign reg_hit    = (paddr == REG_TIMEOUT_ADDR);
  assign timeout_we = psel && penable && pwrite && reg_hit;
  assign prdata     = reg_hit ? APB_DATA_W'(timeout_ticks) : '0;

  itrfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  itrfr_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .rx_byte       (in_rx_byte),
    .timeout_we    (timeout_we),
    .timeout_wdata (pwdata[TICK_W-1:0]),
    .timeout_ticks (timeout_ticks),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_msg_byte  (out_msg_byte),
    .out_msg_last  (out_msg_last)
  );

endmodule

[hdl/itrfr_ctrl.sv]
module itrfr_ctrl
  import itrfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   accept;
  cmd_t   cmd_code;

  assign in_ready = in_ready_r;
  assign accept   = in_valid && in_ready_r;
  assign cmd_code = cmd_t'(in_cmd);

  always_comb begin
    cmd          = '0;
    cmd.wr_byte  = accept && (cmd_code == CMD_BYTE);
    cmd.arm      = accept && (cmd_code == CMD_EDGE);
    cmd.tick     = accept && (cmd_code == CMD_TICK);
    cmd.rd_issue = (state_r == ST_DRAIN) && status.rd_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          // a tick that reaches the timeout closes the message
          if (cmd.tick && status.timeout_hit) begin
            state_r    <= ST_DRAIN;
            in_ready_r <= 1'b0;
          end
        end
        ST_DRAIN: begin
          if (cmd.rd_issue && status.rd_last) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

[hdl/itrfr_dp.sv]
module itrfr_dp
  import itrfr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [BYTE_W-1:0]     rx_byte,
  input  logic                  timeout_we,
  input  logic [TICK_W-1:0]     timeout_wdata,
  output logic [TICK_W-1:0]     timeout_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_msg_byte,
  output logic                  out_msg_last
);

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];

  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [TICK_W-1:0] idle_cnt_r;
  logic [TICK_W-1:0] idle_cnt_nxt;
  logic              armed_r;
  logic [TICK_W-1:0] timeout_r;

  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_last_r;
  logic              rd_vld_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_vld_r;
  logic              load_out;

  assign wr_ptr_nxt   = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt   = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign idle_cnt_nxt = idle_cnt_r + 1'b1;

  // Output stage takes the read stage when it is empty or being emptied
  assign load_out = rd_vld_r && (!out_vld_r || out_ready);

  always_comb begin
    status             = '0;
    status.timeout_hit = armed_r && (idle_cnt_nxt == timeout_r);
    status.rd_free     = !rd_vld_r || load_out;
    status.rd_last     = (rd_ptr_nxt == wr_ptr_r);
  end

  assign timeout_ticks = timeout_r;
  assign out_valid     = out_vld_r;
  assign out_msg_byte  = out_byte_r;
  assign out_msg_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      ring_mem[wr_ptr_r] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= ring_mem[rd_ptr_r];
      rd_last_r <= status.rd_last;
    end
    if (load_out) begin
      out_byte_r <= rd_data_r;
      out_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      idle_cnt_r <= '0;
      armed_r    <= 1'b0;
      timeout_r  <= TIMEOUT_RESET;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (timeout_we) begin
        timeout_r <= timeout_wdata;
      end
      if (cmd.wr_byte) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (cmd.arm) begin
        idle_cnt_r <= '0;
        armed_r    <= 1'b1;
      end else if (cmd.tick) begin
        idle_cnt_r <= idle_cnt_nxt;
        if (status.timeout_hit) begin
          armed_r <= 1'b0;
        end
      end
      if (cmd.rd_issue) begin
        rd_ptr_r <= rd_ptr_nxt;
        rd_vld_r <= 1'b1;
      end else if (load_out) begin
        rd_vld_r <= 1'b0;
      end
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

[test/frame_checker.sv]
`timescale 1ns / 1ps

module frame_checker
  import itrfr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [BYTE_W-1:0]     out_msg_byte,
  input  logic                  out_msg_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } msg_beat_t;

  logic [BYTE_W-1:0] ring [RING_DEPTH];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  logic [TICK_W-1:0] idle_cnt;
  logic [TICK_W-1:0] timeout_ticks;
  logic              armed;
  msg_beat_t         msg_due_q[$];

  // Queue every byte from the read pointer up to the write pointer
  task automatic close_message();
    int unsigned count;
    int unsigned pos;
    int unsigned k;
    msg_beat_t   beat;
    count = (wr_ptr > rd_ptr) ? wr_ptr - rd_ptr : RING_DEPTH - rd_ptr + wr_ptr;
    pos = rd_ptr;
    for (k = 0; k < count; k++) begin
      beat.data = ring[PTR_W'(pos)];
      beat.last = (k + 1 == count);
      msg_due_q.push_back(beat);
      pos = (pos + 1) % RING_DEPTH;
    end
    rd_ptr = wr_ptr;
  endtask

  always @(posedge clk) begin
    msg_beat_t beat;
    if (!rst_n) begin
      wr_ptr        = 0;
      rd_ptr        = 0;
      idle_cnt      = '0;
      armed         = 1'b0;
      timeout_ticks = TIMEOUT_RESET;
      errors        = 0;
      msg_due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_TIMEOUT_ADDR) begin
        timeout_ticks = pwdata[TICK_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (msg_due_q.size() == 0) begin
          $error("msg_byte: expected nothing, actual %0h", out_msg_byte);
          errors++;
        end else begin
          beat = msg_due_q.pop_front();
          if (out_msg_byte !== beat.data) begin
            $error("msg_byte: expected %0h, actual %0h", beat.data, out_msg_byte);
            errors++;
          end
          if (out_msg_last !== beat.last) begin
            $error("msg_last: expected %0b, actual %0b", beat.last, out_msg_last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (cmd_t'(in_cmd))
          CMD_BYTE: begin
            ring[PTR_W'(wr_ptr)] = in_rx_byte;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          end
          CMD_EDGE: begin
            idle_cnt = '0;
            armed    = 1'b1;
          end
          CMD_TICK: begin
            idle_cnt = idle_cnt + 1'b1;
            if (armed && idle_cnt == timeout_ticks) begin
              armed = 1'b0;
              close_message();
            end
          end
          default: ;
        endcase
      end
    end
    pending = msg_due_q.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import itrfr_pkg::*;

  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned PTR_W        = $clog2(RING_DEPTH);
  localparam int          LIMIT_CYCLES = 2000000;
  // Quiet cycles before a register write
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_SLACK   = 20;
  // Byte address of register index 1, which does not exist
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd = '0;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_msg_byte;
  logic                  out_msg_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int pending;
  int cycle_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Shadow of the line state, used only to shape stimulus: it keeps the
  // stimulus from closing a message that would read ring entries never written.
  int unsigned       line_wr;
  int unsigned       line_rd;
  logic [TICK_W-1:0] line_cnt;
  logic [TICK_W-1:0] line_timeout;
  bit                line_armed;
  bit                written [RING_DEPTH];

  idle_timeout_ring_frame_receiver_core #(
    .RING_DEPTH (RING_DEPTH)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_msg_byte (out_msg_byte),
    .out_msg_last (out_msg_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  frame_checker #(
    .RING_DEPTH (RING_DEPTH)
  ) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_msg_byte (out_msg_byte),
    .out_msg_last (out_msg_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the message stream at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Present one command and hold it until the transaction completes. A tick
  // that would close a message over never-written entries becomes a byte.
  task automatic send_cmd(input cmd_t cmd, input logic [BYTE_W-1:0] data);
    cmd_t        c;
    bit          blank;
    int unsigned count;
    int unsigned pos;
    int unsigned k;
    c = cmd;
    blank = 1'b0;
    if (c == CMD_TICK && line_armed && TICK_W'(line_cnt + 1'b1) == line_timeout) begin
      count = (line_wr > line_rd) ? line_wr - line_rd : RING_DEPTH - line_rd + line_wr;
      pos = line_rd;
      for (k = 0; k < count; k++) begin
        if (!written[PTR_W'(pos)]) blank = 1'b1;
        pos = (pos + 1) % RING_DEPTH;
      end
    end
    if (blank) c = CMD_BYTE;
    // Insert sender gaps
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_rx_byte <= data;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    // Advance the shadow once the transaction has gone through
    case (c)
      CMD_BYTE: begin
        written[PTR_W'(line_wr)] = 1'b1;
        line_wr = (line_wr + 1) % RING_DEPTH;
      end
      CMD_EDGE: begin
        line_cnt   = '0;
        line_armed = 1'b1;
      end
      CMD_TICK: begin
        line_cnt = line_cnt + 1'b1;
        if (line_armed && line_cnt == line_timeout) begin
          line_armed = 1'b0;
          line_rd    = line_wr;
        end
      end
      default: ;
    endcase
    if (c != CMD_NONE) items_sent++;
  endtask

  // Drop valid and hold off until every expected byte has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; pready is waited on although it stays high
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (addr == REG_TIMEOUT_ADDR) line_timeout = data[TICK_W-1:0];
  endtask

  // One serial message: bytes, the closing rising edge, then idle ticks until
  // the timeout fires. A length of zero picks a random one. Noisy messages
  // carry stray edges, ticks and unused commands between bytes, and some
  // break off early when the line wakes again before the timeout.
  task automatic send_message(input int len_req, input bit noisy);
    int len;
    int r;
    int k;
    if (len_req != 0) begin
      len = len_req;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) len = RING_DEPTH;
      else if (r < 14) len = $urandom_range(RING_DEPTH + 1, RING_DEPTH + 24);
      else len = $urandom_range(1, 12);
    end
    for (k = 0; k < len; k++) begin
      send_cmd(CMD_BYTE, rand_byte());
      if (noisy) begin
        r = $urandom_range(0, 99);
        if (r < 10) send_cmd(CMD_EDGE, rand_byte());
        else if (r < 13) send_cmd(CMD_TICK, rand_byte());
        else if (r < 15) send_cmd(CMD_NONE, rand_byte());
      end
    end
    send_cmd(CMD_EDGE, rand_byte());
    if (noisy && line_timeout > 1 && $urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, int'(line_timeout) - 1)) send_cmd(CMD_TICK, rand_byte());
      send_cmd(CMD_BYTE, rand_byte());
      send_cmd(CMD_EDGE, rand_byte());
    end
    while (line_armed) send_cmd(CMD_TICK, rand_byte());
  endtask

  initial begin
    int ph;
    int phase_end;
    int send_pct [3];
    int recv_pct [3];
    int phase_timeout [3];
    send_pct      = '{12, 66, 0};
    recv_pct      = '{66, 12, 0};
    phase_timeout = '{3, 1, 20};

    line_wr      = 0;
    line_rd      = 0;
    line_cnt     = '0;
    line_armed   = 1'b0;
    line_timeout = TIMEOUT_RESET;
    foreach (written[i]) written[i] = 1'b0;

    // Hold reset, then release
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: only the low half of the data word lands in the register, and
    // a write to the address past it changes nothing.
    cfg_write(REG_TIMEOUT_ADDR, 32'hFFFF_0002);
    cfg_write(UNMAPPED_ADDR, 32'h0000_0001);
    // Tick with the timeout disarmed, then two unused commands
    send_cmd(CMD_TICK, 8'hFF);
    send_cmd(CMD_NONE, 8'hFF);
    send_cmd(CMD_NONE, 8'h00);
    // Three bytes, two at the data extremes, closed after two idle ticks
    send_cmd(CMD_BYTE, 8'h00);
    send_cmd(CMD_BYTE, 8'hFF);
    send_cmd(CMD_BYTE, 8'h5A);
    send_cmd(CMD_EDGE, 8'h00);
    send_cmd(CMD_TICK, 8'h00);
    send_cmd(CMD_TICK, 8'hFF);
    // A further edge part-way through restarts the idle count
    send_cmd(CMD_BYTE, 8'h81);
    send_cmd(CMD_EDGE, 8'hFF);
    send_cmd(CMD_TICK, 8'h00);
    send_cmd(CMD_EDGE, 8'h00);
    send_cmd(CMD_TICK, 8'hFF);
    send_cmd(CMD_TICK, 8'h00);
    // Let the sender wait for the whole message before going on
    wait_drained();

    // Random phases: idling on one side, then the other, then none. Each
    // opens with an exact ring's worth of bytes so that equal pointers at
    // timeout send the whole ring once the ring has been filled.
    for (ph = 0; ph < 3; ph++) begin
      settle();
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      cfg_write(REG_TIMEOUT_ADDR, APB_DATA_W'(phase_timeout[ph]));
      phase_end = items_sent + 90;
      send_message(RING_DEPTH, 1'b0);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 20) begin
          send_cmd(cmd_t'($urandom_range(0, 3)), rand_byte());
        end else begin
          send_message(0, 1'b1);
        end
        if ($urandom_range(0, 99) < 5) wait_drained();
      end
    end

    // Largest timeout: a short idle spell on an armed line closes nothing
    settle();
    cfg_write(REG_TIMEOUT_ADDR, 32'h0000_FFFF);
    send_cmd(CMD_BYTE, rand_byte());
    send_cmd(CMD_BYTE, rand_byte());
    send_cmd(CMD_EDGE, rand_byte());
    repeat (4) send_cmd(CMD_TICK, rand_byte());

    // A zero timeout waits for the counter to wrap, so these ticks close nothing
    settle();
    cfg_write(REG_TIMEOUT_ADDR, 32'h0000_0000);
    repeat (4) send_cmd(CMD_TICK, rand_byte());

    // Back to a short timeout that the running count has not yet reached
    settle();
    cfg_write(REG_TIMEOUT_ADDR, 32'h0000_000C);
    while (line_armed) send_cmd(CMD_TICK, rand_byte());

    // Drain, let the pipeline run dry, then give the verdict
    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
